// File: design/ic3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the 3x3 image convolution block.
// No dependencies; included by the top level through a wildcard import.

package ic3_pkg;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int KROW_W  = 48;
    localparam int PROD_W  = 24;
    localparam int PART_W  = 26;
    localparam int FILT_W  = 28;
    localparam int KSIZE   = 3;

    localparam int APB_AW  = 6;
    localparam int APB_DW  = 64;
    localparam int IDX_W   = 3;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic [10:0] SIZE_RESET = 11'd1024;

    // Register indexes; the byte address is eight times the index.
    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_K_TOP    = 3'd2,
        REG_K_MIDDLE = 3'd3,
        REG_K_BOTTOM = 3'd4
    } cfg_reg_t;

    // Edge and emission flags that travel with one pixel through the pipe.
    typedef struct packed {
        logic emit;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic fend;
    } tap_ctl_t;

    // Signed Q8.8 coefficient at a column of one kernel row.
    function automatic logic signed [COEF_W-1:0] coef_of(
        input logic [KROW_W-1:0] krow,
        input int unsigned       col
    );
        logic signed [COEF_W-1:0] val;
        begin
            val = $signed(krow[COEF_W*col +: COEF_W]);
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/ic3_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module ic3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/image_convolution_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// A result reaches m_tvalid through the stage 1 to stage 4 registers and the output queue.
// Throughput: one pixel transaction per cycle, sustained while results are taken; the
// line buffer RAM is read and written once per pixel, with forwarding between neighbors.
// Reset (rst_n, asynchronous, active low): position counters, window and queue cleared,
// sizes set to 1024 (clamped to the parameters), kernel zero. The line RAM is not cleared.
// Depends on ic3_pkg and ic3_ram.

module image_convolution_3x3
    import ic3_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int KERNEL_SIZE = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input stream.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] pixel
    input  wire logic [0:0]        s_tuser,   // [0] op (1 = drain pad)
    // Output stream.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // [27:0] filtered, [31:28] zero
    output logic                   m_tlast,   // frame_end
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // Column counter indexes the line RAM directly; the row counter may run two rows
    // past the height while the drain pads flush the last row.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 4);
    localparam int XW = ((RW > WW) ? RW : WW) + 1;
    localparam int KS = KERNEL_SIZE;

    localparam logic [WW-1:0] W_RESET =
        WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
    localparam logic [HW-1:0] H_RESET =
        HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

    // ------------------------------------------------------------------
    // Configuration registers. The raw values are kept for readback and the
    // clamped sizes are computed once at write time.
    // ------------------------------------------------------------------
    logic [10:0]       width_raw_reg;
    logic [10:0]       height_raw_reg;
    logic [KROW_W-1:0] kern_reg [KS];
    logic [WW-1:0]     w_reg;
    logic [HW-1:0]     h_reg;
    logic              cfg_wr;
    logic [IDX_W-1:0]  cfg_idx;
    logic [10:0]       size_in;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:APB_AW-IDX_W];
    assign size_in = pwdata[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= SIZE_RESET;
            height_raw_reg <= SIZE_RESET;
            w_reg          <= W_RESET;
            h_reg          <= H_RESET;
            for (int i = 0; i < KS; i++)
            begin
                kern_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WIDTH:
                begin
                    width_raw_reg <= size_in;
                    if (size_in == 11'd0)
                        w_reg <= WW'(1);
                    else if (32'(size_in) > MAX_WIDTH)
                        w_reg <= WW'(MAX_WIDTH);
                    else
                        w_reg <= WW'(size_in);
                end
                REG_HEIGHT:
                begin
                    height_raw_reg <= size_in;
                    if (size_in == 11'd0)
                        h_reg <= HW'(1);
                    else if (32'(size_in) > MAX_HEIGHT)
                        h_reg <= HW'(MAX_HEIGHT);
                    else
                        h_reg <= HW'(size_in);
                end
                REG_K_TOP:    kern_reg[0] <= pwdata[KROW_W-1:0];
                REG_K_MIDDLE: kern_reg[1] <= pwdata[KROW_W-1:0];
                REG_K_BOTTOM: kern_reg[2] <= pwdata[KROW_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:    prdata = APB_DW'(width_raw_reg);
            REG_HEIGHT:   prdata = APB_DW'(height_raw_reg);
            REG_K_TOP:    prdata = APB_DW'(kern_reg[0]);
            REG_K_MIDDLE: prdata = APB_DW'(kern_reg[1]);
            REG_K_BOTTOM: prdata = APB_DW'(kern_reg[2]);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input acceptance. occ_reg counts results that are promised but not yet
    // taken: in flight in the pipe or waiting in the output queue. Only
    // transactions that will produce a result reserve a queue slot, so the
    // block stops accepting pixels only once every queue slot is reserved.
    // ------------------------------------------------------------------
    logic [FIFO_CW-1:0] occ_reg;
    logic               s_accept;
    logic               m_accept;

    assign s_tready = (occ_reg < FIFO_CW'(FIFO_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // ------------------------------------------------------------------
    // Stage 0: position of the incoming pixel, edge flags of the output
    // position it completes, and the line RAM read.
    // ------------------------------------------------------------------
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;

    logic [XW-1:0] wx, hx, c0x, r0x, c1x, r1x, cx, rx, crx, ccx, sub_x, c2x;
    logic          wrap_in, restart, c_is0, cr_neg;
    tap_ctl_t      ctl0;

    always_comb
    begin
        wx  = XW'(w_reg);
        hx  = XW'(h_reg);
        c0x = XW'(col_cnt_reg);
        r0x = XW'(row_cnt_reg);

        // A column beyond the width starts a new row; a row too far past the
        // height restarts the frame.
        wrap_in = (c0x >= wx);
        c1x     = wrap_in ? '0 : c0x;
        r1x     = wrap_in ? (r0x + XW'(1)) : r0x;
        restart = (r1x > (hx + XW'(1)));
        cx      = restart ? '0 : c1x;
        rx      = restart ? '0 : r1x;

        // The completed window is centered one row and one column back.
        c_is0  = (cx == '0);
        sub_x  = c_is0 ? XW'(2) : XW'(1);
        cr_neg = (rx < sub_x);
        crx    = rx - sub_x;
        ccx    = c_is0 ? (wx - XW'(1)) : (cx - XW'(1));

        ctl0.emit   = !cr_neg && (crx < hx);
        ctl0.top    = (crx == '0);
        ctl0.bottom = (crx == (hx - XW'(1)));
        ctl0.left   = (ccx == '0);
        ctl0.right  = (ccx == (wx - XW'(1)));
        ctl0.fend   = ctl0.emit && ctl0.bottom && ctl0.right;

        c2x = cx + XW'(1);
        if (ctl0.fend)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (c2x >= wx)
        begin
            col_cnt_next = '0;
            row_cnt_next = RW'(rx + XW'(1));
        end
        else
        begin
            col_cnt_next = CW'(c2x);
            row_cnt_next = RW'(rx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (s_accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line RAM: bits [7:0] hold the previous row, bits [15:8] the row before it.
    logic [2*PIX_W-1:0] ram_rd_data;
    logic [2*PIX_W-1:0] ram_wr_data;
    logic [CW-1:0]      rd_addr;

    assign rd_addr = CW'(cx);

    // ------------------------------------------------------------------
    // Stage 1: RAM data arrives, the column vector enters the window, and the
    // rows shift down by one in the line RAM. When the pixel before this one
    // wrote the same entry (image width of one) in the cycle of our read,
    // its values are forwarded.
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    tap_ctl_t          s1_ctl_reg;

    logic              wb_valid_reg;
    logic [CW-1:0]     wb_addr_reg;
    logic [PIX_W-1:0]  wb_a_reg;
    logic [PIX_W-1:0]  wb_b_reg;

    logic              fwd;
    logic [PIX_W-1:0]  line_a;
    logic [PIX_W-1:0]  line_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s_accept;
            wb_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= s_tuser[0] ? '0 : s_tdata;
            s1_ctl_reg  <= ctl0;
        end
        if (s1_valid_reg)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_a_reg    <= s1_pix_reg;
            wb_b_reg    <= line_a;
        end
    end

    assign fwd         = wb_valid_reg && (wb_addr_reg == s1_addr_reg);
    assign line_a      = fwd ? wb_a_reg : ram_rd_data[PIX_W-1:0];
    assign line_b      = fwd ? wb_b_reg : ram_rd_data[2*PIX_W-1:PIX_W];
    assign ram_wr_data = {line_a, s1_pix_reg};

    ic3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Window: win_reg[row][col], row 0 oldest line, col 2 newest column.
    logic [PIX_W-1:0] win_reg [KS][KS];
    tap_ctl_t         s2_ctl_reg;
    logic             s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int r = 0; r < KS; r++)
            begin
                for (int c = 0; c < KS; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < KS; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= line_b;
                win_reg[1][2] <= line_a;
                win_reg[2][2] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: nine products of pixel and flipped coefficient. Taps that fall
    // outside the image are forced to zero, which also hides line RAM entries
    // that were never written.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_next [KS][KS];
    logic signed [PROD_W-1:0] prod_reg  [KS][KS];
    logic                     s3_valid_reg;
    logic                     s3_fend_reg;

    always_comb
    begin
        logic signed [PROD_W:0] full;
        logic                   use_tap;
        for (int r = 0; r < KS; r++)
        begin
            for (int c = 0; c < KS; c++)
            begin
                use_tap = !((r == 0) && s2_ctl_reg.top)
                       && !((r == KS - 1) && s2_ctl_reg.bottom)
                       && !((c == 0) && s2_ctl_reg.left)
                       && !((c == KS - 1) && s2_ctl_reg.right);
                full = $signed({1'b0, win_reg[r][c]})
                     * coef_of(kern_reg[KS - 1 - r], KS - 1 - c);
                prod_next[r][c] = use_tap ? full[PROD_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            prod_reg    <= prod_next;
            s3_fend_reg <= s2_ctl_reg.fend;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: row sums, registered.
    // ------------------------------------------------------------------
    logic signed [PART_W-1:0] part_next [KS];
    logic signed [PART_W-1:0] part_reg  [KS];
    logic                     s4_valid_reg;
    logic                     s4_fend_reg;

    always_comb
    begin
        for (int r = 0; r < KS; r++)
        begin
            part_next[r] = PART_W'(prod_reg[r][0]) + PART_W'(prod_reg[r][1])
                         + PART_W'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            part_reg    <= part_next;
            s4_fend_reg <= s3_fend_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final sum written into the output queue. The queue is deep
    // enough for every promised result, so a push never finds it full.
    // ------------------------------------------------------------------
    logic signed [FILT_W-1:0] sum_final;
    logic [FILT_W-1:0]        fifo_data_reg [FIFO_DEPTH];
    logic                     fifo_last_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_ptr_reg;
    logic [FIFO_AW-1:0]       rd_ptr_reg;
    logic [FIFO_CW-1:0]       fifo_cnt_reg;
    logic [FIFO_CW-1:0]       occ_next;
    logic [FIFO_CW-1:0]       fifo_cnt_next;

    assign sum_final = FILT_W'(part_reg[0]) + FILT_W'(part_reg[1]) + FILT_W'(part_reg[2]);

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            fifo_data_reg[wr_ptr_reg] <= sum_final;
            fifo_last_reg[wr_ptr_reg] <= s4_fend_reg;
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (s_accept && ctl0.emit)
            occ_next = occ_next + FIFO_CW'(1);
        if (m_accept)
            occ_next = occ_next - FIFO_CW'(1);

        fifo_cnt_next = fifo_cnt_reg;
        if (s4_valid_reg)
            fifo_cnt_next = fifo_cnt_next + FIFO_CW'(1);
        if (m_accept)
            fifo_cnt_next = fifo_cnt_next - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            fifo_cnt_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            occ_reg      <= occ_next;
            fifo_cnt_reg <= fifo_cnt_next;
            if (s4_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (m_accept)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {{(32 - FILT_W){1'b0}}, fifo_data_reg[rd_ptr_reg]};
    assign m_tlast  = fifo_last_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_convolution_3x3: streams raster images, predicts every
// zero-padded 3x3 convolution result in its own model and compares each output transaction.
// Depends on ic3_pkg and on the image_convolution_3x3 RTL; reads no files.

module tb_top
    import ic3_pkg::*;
;

    // Pixel transaction kinds carried in s_tuser.
    typedef enum bit {
        OP_PIXEL = 1'b0,
        OP_PAD   = 1'b1
    } pix_op_t;

    typedef struct packed {
        pix_op_t    op;
        logic [7:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic [FILT_W-1:0] filtered;
        logic              frame_end;
    } conv_result_t;

    localparam int SIZE_LIMIT = 1024;     // MAX_WIDTH and MAX_HEIGHT of the instance
    localparam int HOLD_CYCLES = 300;     // long output stall that backs up the pipeline
    localparam int SETTLE_CYCLES = 8;     // settling wait after the last result so that the pipeline is empty
    localparam int SMALL_TARGET = 340;    // pixel transactions in the randomized phases

    logic              clk;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'd0;    // [7:0] pixel
    logic [0:0]        s_tuser = 1'b0;    // [0] op (1 = drain pad)
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;           // [27:0] filtered, [31:28] zero
    logic              m_tlast;           // frame_end
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    image_convolution_3x3 i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the configuration registers, updated on the APB write edge.
    logic [10:0]       cfg_width = SIZE_RESET;
    logic [10:0]       cfg_height = SIZE_RESET;
    logic [KROW_W-1:0] cfg_krow [0:2] = '{default: '0};

    // Convolution model state: two previous rows, the 3x3 window and the next position.
    logic [7:0] row_above [0:SIZE_LIMIT-1] = '{default: 8'd0};
    logic [7:0] row_above2 [0:SIZE_LIMIT-1] = '{default: 8'd0};
    logic [7:0] win [0:2][0:2] = '{default: 8'd0};
    int         pos_col = 0;
    int         pos_row = 0;

    // Stimulus generator position; it runs ahead of the model but follows the same rules.
    int         gen_col = 0;
    int         gen_row = 0;

    pix_item_t    pixel_feed [$];
    conv_result_t result_due [$];

    int items_sent = 0;
    int items_taken = 0;
    int results_seen = 0;
    int frames_done = 0;
    int config_writes = 0;
    int fail_count = 0;

    bit idle_on = 1'b0;
    bit in_took = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int feed_gap = 0;
    int sink_gap = 0;

    // Sizes as the block uses them: zero counts as one, large values clamp to the limit.
    function automatic int eff_size(input logic [10:0] v);
        if (v == 11'd0)
            return 1;
        if (v > SIZE_LIMIT)
            return SIZE_LIMIT;
        return int'(v);
    endfunction

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Advance the model by one accepted pixel transaction and queue the result it causes.
    task automatic convolve_item(input pix_op_t op, input logic [7:0] pixel);
        int           w;
        int           h;
        int           c;
        int           r;
        int           cr;
        int           cc;
        int           sum;
        int           i;
        int           j;
        logic [7:0]   pv;
        conv_result_t res;
        w = eff_size(cfg_width);
        h = eff_size(cfg_height);
        c = pos_col;
        r = pos_row;
        pv = (op == OP_PAD) ? 8'd0 : pixel;
        // A shrunken width wraps to the next row; running too far past the height restarts.
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r > h + 1)
        begin
            r = 0;
            c = 0;
        end
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = row_above2[c];
        win[1][2] = row_above[c];
        win[2][2] = pv;
        row_above2[c] = row_above[c];
        row_above[c] = pv;
        // The window centre trails the input by one row and one column.
        if (c >= 1)
        begin
            cr = r - 1;
            cc = c - 1;
        end
        else
        begin
            cr = r - 2;
            cc = w - 1;
        end
        if (cr >= 0 && cr < h)
        begin
            sum = 0;
            for (i = 0; i < 3; i++)
            begin
                for (j = 0; j < 3; j++)
                begin
                    // Taps outside the image are zero padding.
                    if ((i == 0 && cr == 0) || (i == 2 && cr == h - 1) ||
                        (j == 0 && cc == 0) || (j == 2 && cc == w - 1))
                        continue;
                    // True convolution: the kernel is applied flipped in both directions.
                    sum += int'(win[i][j]) *
                           int'($signed(cfg_krow[2 - i][COEF_W * (2 - j) +: COEF_W]));
                end
            end
            res.filtered = FILT_W'(sum);
            res.frame_end = (cr == h - 1) && (cc == w - 1);
            result_due = {result_due, res};
            if (res.frame_end)
            begin
                pos_col = 0;
                pos_row = 0;
                return;
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        pos_col = c;
        pos_row = r;
    endtask

    // Queue pixel transactions from the current generator position, up to a count or through
    // the transaction that ends the frame. Plain frames have no pads inside the image and
    // alternate pads and pixels in the drain region.
    task automatic queue_items(input int limit, input bit plain, input int fixed_pix);
        int        w;
        int        h;
        int        n;
        bit        at_end;
        pix_item_t it;
        w = eff_size(cfg_width);
        h = eff_size(cfg_height);
        n = 0;
        at_end = 1'b0;
        while (n < limit && !at_end)
        begin
            if (gen_col >= w)
            begin
                gen_col = 0;
                gen_row++;
            end
            if (gen_row > h + 1)
            begin
                gen_row = 0;
                gen_col = 0;
            end
            if (gen_row < h)
                it.op = (!plain && $urandom_range(0, 15) == 0) ? OP_PAD : OP_PIXEL;
            else if (plain)
                it.op = (gen_col % 2 == 1) ? OP_PIXEL : OP_PAD;
            else
                it.op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_PAD;
            it.pixel = (fixed_pix >= 0) ? fixed_pix[7:0] : random_pixel();
            pixel_feed = {pixel_feed, it};
            items_sent++;
            n++;
            at_end = (gen_row == h + 1 && gen_col == 0);
            if (at_end)
            begin
                gen_row = 0;
                gen_col = 0;
            end
            else
            begin
                gen_col++;
                if (gen_col >= w)
                begin
                    gen_col = 0;
                    gen_row++;
                end
            end
        end
    endtask

    // APB write: setup cycle, then access cycle; the register updates when pready is seen.
    task automatic apb_write(input cfg_reg_t idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 3'b000});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_WIDTH:    cfg_width = value[10:0];
            REG_HEIGHT:   cfg_height = value[10:0];
            REG_K_TOP:    cfg_krow[0] = value[KROW_W-1:0];
            REG_K_MIDDLE: cfg_krow[1] = value[KROW_W-1:0];
            REG_K_BOTTOM: cfg_krow[2] = value[KROW_W-1:0];
            default: ;
        endcase
        config_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Size writes carry random bits above the 11-bit field, which the block must ignore.
    task automatic write_sizes(input int w, input int h);
        apb_write(REG_WIDTH, {32'($urandom()), 21'($urandom()), 11'(w)});
        apb_write(REG_HEIGHT, {32'($urandom()), 21'($urandom()), 11'(h)});
    endtask

    task automatic write_kernel_row(input cfg_reg_t idx);
        apb_write(idx, {16'($urandom()), random_coef(), random_coef(), random_coef()});
    endtask

    // Wait until every queued transaction was taken and every predicted result arrived,
    // then let the pipeline settle so that no transaction is still in flight.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != items_sent || result_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Input driver: holds each transaction until it is taken, with random gaps between them.
    always @(negedge clk)
    begin
        pix_item_t item;
        if (rst_n && (!s_tvalid || in_took))
        begin
            if (feed_gap > 0)
            begin
                s_tvalid <= 1'b0;
                feed_gap--;
            end
            else if (idle_on && pixel_feed.size() > 0 && $urandom_range(0, 9) == 0)
            begin
                s_tvalid <= 1'b0;
                feed_gap = $urandom_range(1, 12) - 1;
            end
            else if (pixel_feed.size() > 0)
            begin
                item = pixel_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= item.pixel;
                s_tuser <= item.op;
            end
            else
                s_tvalid <= 1'b0;
        end
        in_took = 1'b0;
    end

    // Output ready: random stall bursts, plus one long stall on request that fills the block.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap = $urandom_range(1, 12) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: checks each output transaction against the oldest prediction, then feeds the
    // model with the input transaction taken at the same edge. A result never belongs to a
    // transaction taken at the same edge, so the check comes first.
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tlast)
                    frames_done++;
                if (result_due.size() == 0)
                begin
                    $error("filtered: expected no result, got %0d", $signed(m_tdata[27:0]));
                    fail_count++;
                end
                else
                begin
                    want = result_due.pop_front();
                    if (m_tdata[27:0] !== want.filtered)
                    begin
                        $error("filtered: expected %0d, got %0d",
                               $signed(want.filtered), $signed(m_tdata[27:0]));
                        fail_count++;
                    end
                    if (m_tlast !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_took = 1'b1;
                items_taken++;
                convolve_item(pix_op_t'(s_tuser[0]), s_tdata);
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int small_items;
        int start_count;
        int cur_w;
        int frame_len;
        int frames;
        int k;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a 3x3 image of full-scale pixels whose centre sees all nine taps, once
        // with the largest and once with the most negative coefficients. The drain rows mix
        // pads with real pixels, which must have no effect.
        write_sizes(3, 3);
        apb_write(REG_K_TOP, {16'h0, {3{16'h7FFF}}});
        apb_write(REG_K_MIDDLE, {16'h0, {3{16'h7FFF}}});
        apb_write(REG_K_BOTTOM, {16'h0, {3{16'h7FFF}}});
        queue_items(1 << 30, 1'b1, 255);
        wait_drained();
        apb_write(REG_K_TOP, {16'h0, {3{16'h8000}}});
        apb_write(REG_K_MIDDLE, {16'h0, {3{16'h8000}}});
        apb_write(REG_K_BOTTOM, {16'h0, {3{16'h8000}}});
        queue_items(1 << 30, 1'b1, 255);
        wait_drained();

        // Widest row: an over-range width clamps to the line length and a zero height counts
        // as one. The frame stops a few columns past the clamped row end, where results show
        // whether the row wrapped at the right place, and then ends at a narrower size.
        idle_on = 1'b1;
        write_sizes(2047, 0);
        write_kernel_row(REG_K_TOP);
        write_kernel_row(REG_K_MIDDLE);
        write_kernel_row(REG_K_BOTTOM);
        queue_items(SIZE_LIMIT + 6, 1'b0, -1);
        wait_drained();
        write_sizes(5, 2);
        queue_items(1 << 30, 1'b0, -1);
        wait_drained();

        // Back-pressure: the output stalls for a long stretch while pixels keep coming.
        write_sizes(16, 8);
        hold_request = 1'b1;
        queue_items(1 << 30, 1'b0, -1);
        wait_drained();

        // Randomized phases, mostly small images. Some phases stop mid-frame, change the
        // sizes while the block is idle and then run on to the end of the frame. The width
        // never grows mid-frame, so no line buffer entry is read before it was written.
        small_items = 0;
        while (small_items < SMALL_TARGET)
        begin
            start_count = items_sent;
            if (small_items > SMALL_TARGET - 100)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            write_sizes(($urandom_range(0, 9) == 0) ? $urandom_range(13, 20)
                                                    : $urandom_range(0, 12),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
                                                    : $urandom_range(0, 8));
            if ($urandom_range(0, 1) == 0)
                write_kernel_row(REG_K_TOP);
            if ($urandom_range(0, 1) == 0)
                write_kernel_row(REG_K_MIDDLE);
            if ($urandom_range(0, 1) == 0)
                write_kernel_row(REG_K_BOTTOM);
            if ($urandom_range(0, 4) == 0)
            begin
                cur_w = eff_size(cfg_width);
                frame_len = cur_w * eff_size(cfg_height) + cur_w + 1;
                queue_items($urandom_range(1, frame_len - 1), 1'b0, -1);
                wait_drained();
                write_sizes($urandom_range(0, cur_w), $urandom_range(0, 10));
                queue_items(1 << 30, 1'b0, -1);
            end
            else
            begin
                frames = $urandom_range(1, 3);
                for (k = 0; k < frames; k++)
                    queue_items(1 << 30, 1'b0, -1);
            end
            wait_drained();
            small_items += items_sent - start_count;
        end

        $display("tb_top: %0d pixel transactions in, %0d results checked, %0d frames ended",
                 items_taken, results_seen, frames_done);
        $display("tb_top: %0d register writes, widths from 1 to the clamp limit, idle and stalls",
                 config_writes);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every gap and stall at its longest.
    initial
    begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: image_convolution_3x3.f
design/ic3_pkg.sv
design/ic3_ram.sv
design/image_convolution_3x3.sv
test/tb_top.sv
